// ===== hw/rtl/pof_pkg.sv =====
// Shared types and constants for the offset-pattern packet filter.
// No dependencies; compiled first.
package pof_pkg;

  // Table depth in bytes; must be a power of two.
  localparam int PACKET_BYTES = 1024;
  localparam int ADDR_W       = $clog2(PACKET_BYTES);
  localparam int POS_W        = ADDR_W + 1;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;

  // Care bits are kept as rows so a clear sweeps one row per cycle.
  localparam int CARE_COLS = 32;
  localparam int COL_W     = $clog2(CARE_COLS);
  localparam int CARE_ROWS = PACKET_BYTES / CARE_COLS;
  localparam int ROW_W     = $clog2(CARE_ROWS);

  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              care;
  } tbl_wr_t;

  // One transaction held in the evaluation stage.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              care;
    logic              last;
    logic [POS_W-1:0]  pos;
  } item_t;

endpackage

// ===== hw/rtl/pof_ifs.sv =====
// Valid/ready channel interfaces for the packet filter input and result streams.
// Depends on pof_pkg.
interface pof_in_if;
  logic                       valid;
  logic                       ready;
  logic [pof_pkg::OP_W-1:0]   opcode;
  logic [pof_pkg::DATA_W-1:0] data_byte;
  logic [pof_pkg::OFF_W-1:0]  entry_offset;
  logic                       care;
  logic                       last;

  modport source (output valid, opcode, data_byte, entry_offset, care, last, input ready);
  modport sink   (input valid, opcode, data_byte, entry_offset, care, last, output ready);
endinterface

interface pof_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [pof_pkg::LEN_W-1:0] packet_length;

  modport source (output valid, accepted, packet_length, input ready);
  modport sink   (input valid, accepted, packet_length, output ready);
endinterface

// ===== hw/rtl/packet_offset_pattern_filter_top.sv =====
// Top level of the offset-pattern packet filter: input stage, position counter,
// read forwarding, table and evaluation. Depends on pof_pkg, pof_ifs, pof_table, pof_eval.
// Throughput: one transaction per cycle unless a result is held or the care sweep runs; a clear
//   transaction holds in_ch.ready low while all CARE_ROWS (32) care rows are swept, one row per cycle.
// Result path: the last byte passes the input/read register, then the result register, before
//   the earliest result handshake.
// Reset: synchronous, active low; after release a care sweep runs before ready.
module packet_offset_pattern_filter_top (
  input  logic      clk,
  input  logic      rst_n,
  pof_in_if.sink    in_ch,
  pof_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic                       filter_en_r;
  logic [pof_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       s1_valid_r;
  pof_pkg::item_t             s1_r, item_nxt;
  logic                       fwd_r, fwd_nxt;
  logic [pof_pkg::DATA_W-1:0] fwd_data_r;
  logic                       fwd_care_r;

  logic                       accept, adv, busy, off_ok, pos_ok;
  logic [pof_pkg::POS_W-1:0]  off_ext;
  logic [pof_pkg::ADDR_W-1:0] rd_addr;
  logic [pof_pkg::DATA_W-1:0] exp_q, exp_byte;
  logic                       care_q, care_bit;
  pof_pkg::tbl_rd_t           rd;
  pof_pkg::tbl_wr_t           wr;

  assign in_ch.ready = !busy && adv;
  assign accept      = in_ch.valid && in_ch.ready;

  assign off_ok  = 32'(in_ch.entry_offset) < pof_pkg::PACKET_BYTES;
  assign pos_ok  = pos_r < pof_pkg::POS_W'(pof_pkg::PACKET_BYTES);
  assign off_ext = pof_pkg::POS_W'(in_ch.entry_offset);
  assign rd_addr = (in_ch.opcode == pof_pkg::OP_LOAD) ? off_ext[pof_pkg::ADDR_W-1:0]
                                                      : pos_r[pof_pkg::ADDR_W-1:0];

  always_comb begin
    item_nxt.opcode   = in_ch.opcode;
    item_nxt.data     = in_ch.data_byte;
    item_nxt.addr     = rd_addr;
    item_nxt.in_range = (in_ch.opcode == pof_pkg::OP_LOAD) ? off_ok : pos_ok;
    item_nxt.care     = in_ch.care;
    item_nxt.last     = in_ch.last;
    item_nxt.pos      = pos_r;
  end

  // Byte position as seen at acceptance; saturates at the table depth.
  always_comb begin
    pos_nxt = pos_r;
    if (in_ch.opcode == pof_pkg::OP_BYTE) begin
      if (in_ch.last) pos_nxt = '0;
      else if (pos_ok) pos_nxt = pos_r + 1'b1;
    end
  end

  // A load in the eval stage writes at the same edge the next read is taken.
  assign fwd_nxt = s1_valid_r && (s1_r.opcode == pof_pkg::OP_LOAD) && s1_r.in_range &&
                   (s1_r.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) filter_en_r <= cfg_wr_data;
      if (accept) begin
        pos_r      <= pos_nxt;
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= item_nxt;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= s1_r.data;
      fwd_care_r <= s1_r.care;
    end
  end

  assign rd.en   = accept;
  assign rd.addr = rd_addr;

  assign wr.en   = s1_valid_r && (s1_r.opcode == pof_pkg::OP_LOAD) && s1_r.in_range;
  assign wr.addr = s1_r.addr;
  assign wr.data = s1_r.data;
  assign wr.care = s1_r.care;

  pof_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_start (accept && (in_ch.opcode == pof_pkg::OP_CLEAR)),
    .rd          (rd),
    .wr          (wr),
    .exp_q       (exp_q),
    .care_q      (care_q),
    .busy        (busy)
  );

  assign exp_byte = fwd_r ? fwd_data_r : exp_q;
  assign care_bit = fwd_r ? fwd_care_r : care_q;

  pof_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid_r),
    .item          (s1_r),
    .exp_byte      (exp_byte),
    .care_bit      (care_bit),
    .filter_enable (filter_en_r),
    .adv           (adv),
    .out_ch        (out_ch)
  );

endmodule

// ===== hw/rtl/pof_table.sv =====
// Filter table: expected-byte memory, row-organized care-bit memory and the clear sweep.
// Depends on pof_pkg.
module pof_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear_start,
  input  pof_pkg::tbl_rd_t           rd,
  input  pof_pkg::tbl_wr_t           wr,
  output logic [pof_pkg::DATA_W-1:0] exp_q,
  output logic                       care_q,
  output logic                       busy
);

  logic [pof_pkg::DATA_W-1:0]    exp_mem  [pof_pkg::PACKET_BYTES];
  logic [pof_pkg::CARE_COLS-1:0] care_mem [pof_pkg::CARE_ROWS];

  logic                       busy_r;
  logic [pof_pkg::ROW_W-1:0]  sweep_row_r;
  logic [pof_pkg::DATA_W-1:0] exp_q_r;
  logic                       care_q_r;

  logic [pof_pkg::ROW_W-1:0] wr_row, rd_row;
  logic [pof_pkg::COL_W-1:0] wr_col, rd_col;

  assign wr_row = wr.addr[pof_pkg::ADDR_W-1:pof_pkg::COL_W];
  assign wr_col = wr.addr[pof_pkg::COL_W-1:0];
  assign rd_row = rd.addr[pof_pkg::ADDR_W-1:pof_pkg::COL_W];
  assign rd_col = rd.addr[pof_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      sweep_row_r <= '0;
    end else if (clear_start) begin
      busy_r      <= 1'b1;
      sweep_row_r <= '0;
    end else if (busy_r) begin
      sweep_row_r <= sweep_row_r + 1'b1;
      if (sweep_row_r == pof_pkg::ROW_W'(pof_pkg::CARE_ROWS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      exp_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      exp_q_r <= exp_mem[rd.addr];
    end
  end

  // Sweep wins; a table write never coincides with it.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      care_mem[sweep_row_r] <= '0;
    end else if (wr.en) begin
      care_mem[wr_row][wr_col] <= wr.care;
    end
    if (rd.en) begin
      care_q_r <= care_mem[rd_row][rd_col];
    end
  end

  assign exp_q  = exp_q_r;
  assign care_q = care_q_r;
  assign busy   = busy_r;

endmodule

// ===== hw/rtl/pof_eval.sv =====
// Evaluation stage: care counters, mismatch tracking and the result register.
// Depends on pof_pkg and pof_out_if.
module pof_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  pof_pkg::item_t             item,
  input  logic [pof_pkg::DATA_W-1:0] exp_byte,
  input  logic                       care_bit,
  input  logic                       filter_enable,
  output logic                       adv,
  pof_out_if.source                  out_ch
);

  // care_count_r: cared entries in the table.
  // below_r: cared entries at offsets already passed in the current packet.
  logic [pof_pkg::POS_W-1:0] care_count_r, care_count_nxt;
  logic [pof_pkg::POS_W-1:0] below_r, below_nxt;
  logic                      mm_r, mm_nxt;
  logic                      out_valid_r;
  logic                      accepted_r, accepted_nxt;
  logic [pof_pkg::LEN_W-1:0] len_r, len_nxt;

  logic has_result, fire, mm_now, passed_off;
  logic [pof_pkg::POS_W-1:0] below_sum, len_full;

  assign has_result = (item.opcode == pof_pkg::OP_BYTE) && item.last;
  assign adv        = !s1_valid || !has_result || !out_valid_r || out_ch.ready;
  assign fire       = s1_valid && adv;

  assign mm_now     = item.in_range && care_bit && (exp_byte != item.data);
  assign below_sum  = below_r + pof_pkg::POS_W'(item.in_range && care_bit);
  assign len_full   = item.pos + pof_pkg::POS_W'(item.in_range);
  assign passed_off = pof_pkg::POS_W'(item.addr) < item.pos;

  always_comb begin
    care_count_nxt = care_count_r;
    below_nxt      = below_r;
    mm_nxt         = mm_r;
    accepted_nxt   = accepted_r;
    len_nxt        = len_r;
    case (item.opcode)
      pof_pkg::OP_LOAD: begin
        if (item.in_range && item.care && !care_bit) begin
          care_count_nxt = care_count_r + 1'b1;
          if (passed_off) below_nxt = below_r + 1'b1;
        end else if (item.in_range && !item.care && care_bit) begin
          care_count_nxt = care_count_r - 1'b1;
          if (passed_off) below_nxt = below_r - 1'b1;
        end
      end
      pof_pkg::OP_CLEAR: begin
        care_count_nxt = '0;
        below_nxt      = '0;
      end
      pof_pkg::OP_BYTE: begin
        if (item.last) begin
          accepted_nxt = !filter_enable ||
                         (!(mm_r || mm_now) && (below_sum == care_count_r));
          len_nxt      = pof_pkg::LEN_W'(len_full);
          below_nxt    = '0;
          mm_nxt       = 1'b0;
        end else begin
          below_nxt = below_sum;
          mm_nxt    = mm_r || mm_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      care_count_r <= '0;
      below_r      <= '0;
      mm_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        care_count_r <= care_count_nxt;
        below_r      <= below_nxt;
        mm_r         <= mm_nxt;
      end
      if (fire && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      accepted_r <= accepted_nxt;
      len_r      <= len_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = accepted_r;
  assign out_ch.packet_length = len_r;

endmodule

// ===== hw/rtl/pof_checker.sv =====
// Port-level checks for the packet filter, attached to the top level by bind.
// Depends on pof_pkg and packet_offset_pattern_filter_top.
module pof_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [pof_pkg::OP_W-1:0]  in_opcode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic [pof_pkg::LEN_W-1:0] out_packet_length
);

  // Care sweep runs right after reset.
  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during post-reset sweep");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == pof_pkg::OP_CLEAR)) |=> !in_ready)
    else $error("input ready while care sweep pending");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packet_length != '0) &&
                  (32'(out_packet_length) <= pof_pkg::PACKET_BYTES))
    else $error("packet length out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_accepted) && $stable(out_packet_length)))
    else $error("stalled result transaction changed");

endmodule

bind packet_offset_pattern_filter_top pof_checker u_pof_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_opcode         (in_ch.opcode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_accepted      (out_ch.accepted),
  .out_packet_length (out_ch.packet_length)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for packet_offset_pattern_filter_top: a queued driver feeds
// table loads, clears and packet bytes while a scoreboard predicts each verdict.
// Depends on pof_pkg, pof_ifs and the filter RTL.
module tb_top;
  import pof_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] data;
    logic [OFF_W-1:0]  offset;
    logic              care;
    logic              last;
  } filter_req_t;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] pkt_len;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  pof_in_if  in_ch();
  pof_out_if out_ch();

  packet_offset_pattern_filter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  filter_req_t pending_q[$];
  verdict_t    verdict_q[$];
  bit          in_taken;
  int          errors;
  int          results_seen;
  int          cycle_count;

  // Shadow table used by the predictor
  logic [DATA_W-1:0]       tbl_byte [PACKET_BYTES];
  bit [PACKET_BYTES-1:0]   tbl_care;
  int                      care_top;
  int                      byte_pos;
  bit                      mismatch;
  bit                      filter_on;

  // Generator's view of the table, kept so packets can be built to match
  logic [DATA_W-1:0]       gen_byte [PACKET_BYTES];
  bit [PACKET_BYTES-1:0]   gen_care;
  int                      hi_offs[$];
  int                      items_queued;
  int                      packets_queued;

  task automatic predict_verdict(input filter_req_t r);
    verdict_t v;
    case (r.opcode)
      OP_LOAD: begin
        tbl_byte[r.offset] = r.data;
        tbl_care[r.offset] = r.care;
        if (r.care) begin
          if (int'(r.offset) + 1 > care_top) care_top = int'(r.offset) + 1;
        end else begin
          while (care_top > 0 && !tbl_care[care_top-1]) care_top--;
        end
      end
      OP_CLEAR: begin
        tbl_care = '0;
        care_top = 0;
      end
      OP_BYTE: begin
        if (byte_pos < PACKET_BYTES) begin
          if (tbl_care[byte_pos] && tbl_byte[byte_pos] != r.data) mismatch = 1'b1;
          byte_pos++;
        end
        if (r.last) begin
          v.accepted = !filter_on || (!mismatch && care_top <= byte_pos);
          v.pkt_len  = byte_pos[LEN_W-1:0];
          verdict_q.push_back(v);
          byte_pos = 0;
          mismatch = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Scoreboard: check results, then predict from the accepted input transaction
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected: accepted=%0b length=%0d",
                   $time, out_ch.accepted, out_ch.packet_length);
          errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (exp_v.accepted !== out_ch.accepted) begin
            $display("%0t: accepted mismatch: expected %0b, actual %0b",
                     $time, exp_v.accepted, out_ch.accepted);
            errors++;
          end
          if (exp_v.pkt_len !== out_ch.packet_length) begin
            $display("%0t: packet_length mismatch: expected %0d, actual %0d",
                     $time, exp_v.pkt_len, out_ch.packet_length);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        predict_verdict('{in_ch.opcode, in_ch.data_byte, in_ch.entry_offset,
                          in_ch.care, in_ch.last});
      end
    end
  end

  // Driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    filter_req_t cur;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        cur = pending_q.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= cur.opcode;
        in_ch.data_byte    <= cur.data;
        in_ch.entry_offset <= cur.offset;
        in_ch.care         <= cur.care;
        in_ch.last         <= cur.last;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 9) < 2) begin
          burst_left = $urandom_range(50, 150);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off while input is offered
  int  rx_mode;
  int  rx_left;
  int  hold_left;
  bit  hold_done;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 20 && in_ch.valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 9) < 6);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("packet_offset_pattern_filter_top verification failed");
      $finish;
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input int data, input int off,
                           input bit care, input bit last);
    filter_req_t r;
    r.opcode = op;
    r.data   = data[DATA_W-1:0];
    r.offset = off[OFF_W-1:0];
    r.care   = care;
    r.last   = last;
    pending_q.push_back(r);
    if (op != 2'(3)) items_queued++;
    if (op == OP_LOAD) begin
      gen_byte[r.offset] = r.data;
      gen_care[r.offset] = care;
    end else if (op == OP_CLEAR) begin
      gen_care = '0;
      hi_offs.delete();
    end else if (op == OP_BYTE && last) begin
      packets_queued++;
    end
  endtask

  // exact: cared offsets carry the expected byte, the rest are random
  task automatic send_packet(input int len, input bit exact);
    int b;
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(0, 29) == 0)
        push_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 31),
                  $urandom_range(0, 1), 1'b0);
      if (exact && p < PACKET_BYTES && gen_care[p]) b = gen_byte[p];
      else b = $urandom_range(0, 255);
      push_item(OP_BYTE, b, $urandom_range(0, 1023), $urandom_range(0, 1), p == len - 1);
    end
  endtask

  task automatic drain(input int settle);
    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_filter(input bit en);
    drain(40);
    cfg_wr_data <= en;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    filter_on = en;
  endtask

  task automatic random_phase(input int n_items);
    int first_items;
    int first_pkts;
    int pick;
    int off;
    first_items = items_queued;
    first_pkts  = packets_queued;
    while (items_queued - first_items < n_items || packets_queued - first_pkts < 12) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3))
          push_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 31),
                    $urandom_range(0, 4) != 0, $urandom_range(0, 1));
      end else if (pick < 10) begin
        off = $urandom_range(0, 1023);
        push_item(OP_LOAD, $urandom_range(0, 255), off, 1'b1, $urandom_range(0, 1));
        hi_offs.push_back(off);
      end else if (pick < 14) begin
        // uncare a far offset so care_top falls back
        if (hi_offs.size() != 0)
          push_item(OP_LOAD, $urandom_range(0, 255), hi_offs.pop_front(), 1'b0,
                    $urandom_range(0, 1));
      end else if (pick < 16) begin
        push_item(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (pick < 18) begin
        push_item(2'(3), $urandom_range(0, 255), $urandom_range(0, 1023),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        send_packet(($urandom_range(0, 99) == 0) ? $urandom_range(1020, 1030)
                                                 : $urandom_range(1, 40),
                    $urandom_range(0, 9) < 7);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_BYTE;
    in_ch.data_byte    = '0;
    in_ch.entry_offset = '0;
    in_ch.care         = 1'b0;
    in_ch.last         = 1'b0;
    out_ch.ready       = 1'b0;
    tbl_care  = '0;
    gen_care  = '0;
    care_top  = 0;
    byte_pos  = 0;
    mismatch  = 1'b0;
    filter_on = 1'b0;
    foreach (tbl_byte[i]) begin
      tbl_byte[i] = '0;
      gen_byte[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Filter off after reset: a mismatch still yields acceptance
    push_item(OP_LOAD, 8'hA5, 0, 1'b1, 1'b0);
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b1);

    set_filter(1'b1);
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b1);          // mismatch at offset 0
    push_item(OP_LOAD, 8'hFF, 1023, 1'b1, 1'b0);
    push_item(OP_LOAD, 8'h00, 1023, 1'b0, 1'b1);       // limit drops back to 1
    push_item(OP_BYTE, 8'hA5, 1023, 1'b1, 1'b1);
    push_item(OP_BYTE, 8'hA5, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'hFF, 0, 1'b0, 1'b1);
    push_item(OP_LOAD, 8'h3C, 3, 1'b1, 1'b0);
    push_item(OP_BYTE, 8'hA5, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b1);          // cared offset past the end
    push_item(2'(3), 8'hFF, 1023, 1'b1, 1'b1);         // ignored opcode
    push_item(OP_BYTE, 8'hA5, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'h3C, 0, 1'b0, 1'b1);
    push_item(OP_CLEAR, 8'h00, 0, 1'b0, 1'b0);
    push_item(OP_BYTE, 8'h5A, 0, 1'b0, 1'b1);          // nothing cared
    // table change mid-packet: offset 0 already compared keeps its outcome
    push_item(OP_BYTE, 8'h00, 0, 1'b0, 1'b0);
    push_item(OP_LOAD, 8'h77, 1, 1'b1, 1'b0);
    push_item(OP_LOAD, 8'h10, 0, 1'b1, 1'b0);
    push_item(OP_BYTE, 8'h77, 0, 1'b0, 1'b1);
    push_item(OP_LOAD, 8'h42, 1023, 1'b1, 1'b0);
    send_packet(1030, 1'b1);                           // overlong, length saturates
    push_item(OP_CLEAR, 8'hFF, 1023, 1'b1, 1'b1);

    set_filter(1'b1);
    random_phase(190);
    set_filter(1'b0);
    random_phase(190);
    set_filter(1'b1);
    random_phase(190);
    set_filter(1'b0);
    set_filter(1'b1);
    random_phase(190);

    drain(20);
    if (errors == 0) begin
      $display("packet_offset_pattern_filter_top verification clean");
    end else begin
      $display("packet_offset_pattern_filter_top verification failed");
    end
    $finish;
  end

endmodule
